/* design/rsl_pkg.sv */
package rsl_pkg;

    localparam int MAX_HASH   = 31;
    localparam int MAX_LENGTH = 65535;

    localparam int POS_W  = $clog2(MAX_LENGTH + 1);
    localparam int HASH_W = $clog2(MAX_HASH + 1);

    // result field widths are fixed by the interface
    localparam int LEN_W  = 16;
    localparam int HCNT_W = 5;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [1:0] NEED_SINGLE = 2'd1;
    localparam logic [1:0] NEED_MULTI  = 2'd3;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_TERM   = 2'd1,
        ST_UNTERM = 2'd2,
        ST_OVER   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        PH_COUNT   = 4'b0001,
        PH_PENDING = 4'b0010,
        PH_SCAN    = 4'b0100,
        PH_DONE    = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_status             scan_status;
        logic [LEN_W-1:0]    literal_length;
        logic [LEN_W-1:0]    content_start;
        logic [HCNT_W-1:0]   hash_count;
        logic                is_multi_line;
    } t_result;

    typedef struct packed {
        logic [1:0]        quote_run;
        logic [HASH_W-1:0] closing_cnt;
        logic [HASH_W-1:0] esc_cnt;
        logic              esc_coll;
        logic              skip;
    } t_scan;

    typedef struct packed {
        t_scan            sc;
        t_status          st;
        logic [POS_W-1:0] len;
    } t_scan_out;

endpackage

/* design/rsl_step.sv */
module rsl_step (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  rsl_pkg::t_in_item       i_item,
    output logic                    o_res_valid,
    output rsl_pkg::t_result        o_res
);

    localparam logic [rsl_pkg::POS_W-1:0] POS_MAX = '1;

    rsl_pkg::t_phase                r_phase,      n_phase;
    logic [rsl_pkg::POS_W-1:0]      r_pos,        n_pos;
    logic [rsl_pkg::HASH_W-1:0]     r_hash_level, n_hash_level;
    rsl_pkg::t_scan                 r_scan,       n_scan;
    logic                           r_ml,         n_ml;
    logic [rsl_pkg::POS_W-1:0]      r_content,    n_content;
    logic                           r_held_valid, n_held_valid;
    rsl_pkg::t_status               r_held_st,    n_held_st;
    logic [rsl_pkg::POS_W-1:0]      r_held_len,   n_held_len;

    function automatic rsl_pkg::t_scan_out scan_byte(
        input logic [7:0]                  b,
        input logic [rsl_pkg::POS_W-1:0]   p,
        input logic                        ml,
        input logic [rsl_pkg::HASH_W-1:0]  h,
        input rsl_pkg::t_scan              sc
    );
        rsl_pkg::t_scan_out         r;
        logic [1:0]                 need;
        logic [rsl_pkg::HASH_W-1:0] cnt;
        logic                       done;
        r      = '0;
        r.sc   = sc;
        r.st   = rsl_pkg::ST_NONE;
        need   = ml ? rsl_pkg::NEED_MULTI : rsl_pkg::NEED_SINGLE;
        cnt    = '0;
        done   = 1'b0;
        if (sc.skip) begin
            r.sc.skip = 1'b0;
            if (!ml && b == rsl_pkg::CH_NL) begin
                r.st  = rsl_pkg::ST_UNTERM;
                r.len = p;
            end
            done = 1'b1;
        end else if (sc.esc_coll) begin
            if (b == rsl_pkg::CH_HASH) begin
                cnt          = sc.esc_cnt + 1'b1;
                r.sc.esc_cnt = cnt;
                if (cnt >= h) begin
                    r.sc.esc_coll = 1'b0;
                    r.sc.skip     = 1'b1;
                end
                done = 1'b1;
            end else begin
                r.sc.esc_coll = 1'b0;
            end
        end
        if (!done) begin
            if (b == rsl_pkg::CH_BSLASH) begin
                r.sc.quote_run   = '0;
                r.sc.closing_cnt = '0;
                if (h == '0) begin
                    r.sc.skip = 1'b1;
                end else begin
                    r.sc.esc_coll = 1'b1;
                    r.sc.esc_cnt  = '0;
                end
            end else if (b == rsl_pkg::CH_NL) begin
                r.sc.quote_run   = '0;
                r.sc.closing_cnt = '0;
                if (!ml) begin
                    r.st  = rsl_pkg::ST_UNTERM;
                    r.len = p;
                end
            end else if (b == rsl_pkg::CH_QUOTE) begin
                if (sc.closing_cnt != '0) begin
                    r.sc.quote_run   = 2'd1;
                    r.sc.closing_cnt = '0;
                end else if (sc.quote_run < need) begin
                    r.sc.quote_run = sc.quote_run + 2'd1;
                end
                if (r.sc.quote_run == need && h == '0) begin
                    r.st  = rsl_pkg::ST_TERM;
                    r.len = p + 1'b1;
                end
            end else if (b == rsl_pkg::CH_HASH) begin
                if (sc.quote_run == need) begin
                    cnt              = sc.closing_cnt + 1'b1;
                    r.sc.closing_cnt = cnt;
                    if (cnt >= h) begin
                        r.st  = rsl_pkg::ST_TERM;
                        r.len = p + 1'b1;
                    end
                end else begin
                    r.sc.quote_run   = '0;
                    r.sc.closing_cnt = '0;
                end
            end else begin
                r.sc.quote_run   = '0;
                r.sc.closing_cnt = '0;
            end
        end
        return r;
    endfunction

    function automatic rsl_pkg::t_result mk_res(
        input rsl_pkg::t_status            st,
        input logic [rsl_pkg::POS_W-1:0]   len,
        input logic [rsl_pkg::POS_W-1:0]   cs,
        input logic [rsl_pkg::HASH_W-1:0]  h,
        input logic                        ml
    );
        rsl_pkg::t_result r;
        r.scan_status    = st;
        r.literal_length = rsl_pkg::LEN_W'(len);
        r.content_start  = rsl_pkg::LEN_W'(cs);
        r.hash_count     = rsl_pkg::HCNT_W'(h);
        r.is_multi_line  = ml;
        return r;
    endfunction

    logic [7:0]                 b;
    logic                       last;
    logic [rsl_pkg::POS_W-1:0]  p_inc;
    logic [rsl_pkg::POS_W-1:0]  k;
    rsl_pkg::t_scan_out         so;
    logic                       go_multi;
    logic                       go_single;
    logic                       held_now;
    rsl_pkg::t_status           held_st_now;
    logic [rsl_pkg::POS_W-1:0]  held_len_now;
    rsl_pkg::t_scan             scan_in;

    assign b     = i_item.source_byte;
    assign last  = i_item.last_byte;
    assign p_inc = r_pos + 1'b1;
    // offset of this byte past the opening quote's position
    assign k     = r_pos - rsl_pkg::POS_W'(r_hash_level);
    assign scan_in = r_scan;

    always_comb begin
        so = scan_byte(b, r_pos, (r_phase == rsl_pkg::PH_SCAN) ? r_ml : 1'b0,
                       r_hash_level, scan_in);
    end

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_hash_level = r_hash_level;
        n_scan       = r_scan;
        n_ml         = r_ml;
        n_content    = r_content;
        n_held_valid = r_held_valid;
        n_held_st    = r_held_st;
        n_held_len   = r_held_len;
        o_res_valid  = 1'b0;
        o_res        = mk_res(rsl_pkg::ST_NONE, '0, '0, '0, 1'b0);
        go_multi     = 1'b0;
        go_single    = 1'b0;
        held_now     = r_held_valid;
        held_st_now  = r_held_st;
        held_len_now = r_held_len;

        if (r_phase != rsl_pkg::PH_DONE && r_pos >= rsl_pkg::POS_W'(rsl_pkg::MAX_LENGTH)) begin
            o_res_valid = 1'b1;
            o_res       = mk_res(rsl_pkg::ST_OVER, '0, '0, '0, 1'b0);
        end else begin
            unique case (r_phase)
                rsl_pkg::PH_COUNT: begin
                    if (b == rsl_pkg::CH_HASH) begin
                        if (r_hash_level >= rsl_pkg::HASH_W'(rsl_pkg::MAX_HASH)) begin
                            o_res_valid = 1'b1;
                            o_res       = mk_res(rsl_pkg::ST_OVER, '0, '0, '0, 1'b0);
                        end else begin
                            n_hash_level = r_hash_level + 1'b1;
                            if (last) begin
                                o_res_valid = 1'b1;
                            end
                        end
                    end else if (b == rsl_pkg::CH_QUOTE) begin
                        n_phase      = rsl_pkg::PH_PENDING;
                        n_content    = p_inc;
                        n_ml         = 1'b0;
                        n_scan       = '0;
                        n_held_valid = 1'b0;
                        if (last) begin
                            o_res_valid = 1'b1;
                            o_res = mk_res(rsl_pkg::ST_UNTERM, p_inc, p_inc,
                                           r_hash_level, 1'b0);
                        end
                    end else begin
                        o_res_valid = 1'b1;
                    end
                end
                rsl_pkg::PH_PENDING: begin
                    // single-line scan runs until its first outcome, then is held
                    if (!r_held_valid) begin
                        n_scan = so.sc;
                        if (so.st != rsl_pkg::ST_NONE) begin
                            held_now     = 1'b1;
                            held_st_now  = so.st;
                            held_len_now = so.len;
                        end
                    end
                    n_held_valid = held_now;
                    n_held_st    = held_st_now;
                    n_held_len   = held_len_now;
                    if (k <= rsl_pkg::POS_W'(2)) begin
                        go_single = (b != rsl_pkg::CH_QUOTE);
                    end else if (b == rsl_pkg::CH_NL) begin
                        go_multi = 1'b1;
                    end else if (b == rsl_pkg::CH_HASH || b == rsl_pkg::CH_QUOTE) begin
                        go_single = 1'b1;
                    end
                    if (!go_multi && !go_single && last) begin
                        go_single = 1'b1;
                    end
                    if (go_multi) begin
                        n_phase      = rsl_pkg::PH_SCAN;
                        n_ml         = 1'b1;
                        n_content    = p_inc;
                        n_scan       = '0;
                        n_held_valid = 1'b0;
                        if (last) begin
                            o_res_valid = 1'b1;
                            o_res = mk_res(rsl_pkg::ST_UNTERM, p_inc, p_inc,
                                           r_hash_level, 1'b1);
                        end
                    end else if (go_single) begin
                        n_phase = rsl_pkg::PH_SCAN;
                        if (held_now) begin
                            o_res_valid = 1'b1;
                            o_res = mk_res(held_st_now, held_len_now, r_content,
                                           r_hash_level, 1'b0);
                        end else if (last) begin
                            o_res_valid = 1'b1;
                            o_res = mk_res(rsl_pkg::ST_UNTERM, p_inc, r_content,
                                           r_hash_level, 1'b0);
                        end
                    end
                end
                rsl_pkg::PH_SCAN: begin
                    n_scan = so.sc;
                    if (so.st != rsl_pkg::ST_NONE) begin
                        o_res_valid = 1'b1;
                        o_res = mk_res(so.st, so.len, r_content, r_hash_level, r_ml);
                    end else if (last) begin
                        o_res_valid = 1'b1;
                        o_res = mk_res(rsl_pkg::ST_UNTERM, p_inc, r_content,
                                       r_hash_level, r_ml);
                    end
                end
                rsl_pkg::PH_DONE: begin
                end
                default: begin
                end
            endcase
        end

        if (last) begin
            n_phase      = rsl_pkg::PH_COUNT;
            n_pos        = '0;
            n_hash_level = '0;
            n_scan       = '0;
            n_ml         = 1'b0;
            n_content    = '0;
            n_held_valid = 1'b0;
        end else begin
            if (o_res_valid) begin
                n_phase = rsl_pkg::PH_DONE;
            end
            if (r_pos != POS_MAX) begin
                n_pos = p_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= rsl_pkg::PH_COUNT;
            r_pos        <= '0;
            r_hash_level <= '0;
            r_scan       <= '0;
            r_ml         <= 1'b0;
            r_content    <= '0;
            r_held_valid <= 1'b0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_hash_level <= n_hash_level;
            r_scan       <= n_scan;
            r_ml         <= n_ml;
            r_content    <= n_content;
            r_held_valid <= n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_held_st  <= n_held_st;
            r_held_len <= n_held_len;
        end
    end

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == rsl_pkg::PH_DONE) |-> !o_res_valid)
        else $error("result produced after the text was already resolved");

    a_hash_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hash_level <= rsl_pkg::HASH_W'(rsl_pkg::MAX_HASH))
        else $error("hash level beyond bound");

    a_over_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.scan_status == rsl_pkg::ST_OVER
                         || o_res.scan_status == rsl_pkg::ST_NONE))
        |-> (o_res.literal_length == '0 && o_res.content_start == '0
             && o_res.hash_count == '0 && !o_res.is_multi_line))
        else $error("overflow or non-literal result carries nonzero fields");

    a_result_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res_valid && !last) |=> r_phase == rsl_pkg::PH_DONE)
        else $error("scanner kept running after a result");

endmodule

/* design/raw_string_literal_delimiter_scanner.sv */
// A byte is taken into the input register; its outcome goes into the result register when that
// register is free or being read, and shows on o_result from there.
// Throughput: one byte per cycle while the output is not stalled; the per-byte step is one pass
// of counter/compare logic between the input register and the result register.
// Reset (i_rst_n low, synchronous): both registers empty, scanner back to counting hashes.
module raw_string_literal_delimiter_scanner (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rsl_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rsl_pkg::t_result     o_result
);

    logic               r_in_valid;
    rsl_pkg::t_in_item  r_in;
    logic               r_out_valid;
    rsl_pkg::t_result   r_out;
    logic               adv;
    logic               res_valid;
    rsl_pkg::t_result   res;

    // step the held byte whenever the result register can take its outcome
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;

    rsl_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv),
        .i_item      (r_in),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= (r_in_valid && !adv) || (i_in_valid && !o_in_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

/* bench/raw_string_literal_delimiter_scanner_test.sv */
// Tracks the literal scan byte by byte and holds the results the block owes.
class literal_checker;
    int unsigned      pos;
    rsl_pkg::t_phase  phase;
    int unsigned      hlev;
    int unsigned      qrun;
    int unsigned      close_cnt;
    int unsigned      esc_cnt;
    bit               esc_coll;
    bit               skip;
    bit               multi;
    int unsigned      content_at;
    bit               held_valid;
    rsl_pkg::t_status held_st;
    int unsigned      held_len;

    rsl_pkg::t_result awaited_results[$];
    int unsigned      errors;
    int unsigned      reported;
    int unsigned      status_seen[4];
    int unsigned      multi_seen;

    function new();
        errors = 0;
        reported = 0;
        multi_seen = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        restart();
    endfunction

    function void clear_scan();
        qrun = 0;
        close_cnt = 0;
        esc_cnt = 0;
        esc_coll = 0;
        skip = 0;
    endfunction

    function void restart();
        pos = 0;
        phase = rsl_pkg::PH_COUNT;
        hlev = 0;
        clear_scan();
        multi = 0;
        content_at = 0;
        held_valid = 0;
        held_st = rsl_pkg::ST_NONE;
        held_len = 0;
    endfunction

    function rsl_pkg::t_result make_result(rsl_pkg::t_status st, int unsigned len,
                                           int unsigned cs, int unsigned h, bit ml);
        rsl_pkg::t_result r;
        r.scan_status = st;
        r.literal_length = len[rsl_pkg::LEN_W-1:0];
        r.content_start = cs[rsl_pkg::LEN_W-1:0];
        r.hash_count = h[rsl_pkg::HCNT_W-1:0];
        r.is_multi_line = ml;
        return r;
    endfunction

    // One byte of the literal body; ST_NONE while the literal goes on.
    function rsl_pkg::t_status scan_body(logic [7:0] b, int unsigned p, bit ml,
                                         output int unsigned len);
        int unsigned need;
        need = ml ? 3 : 1;
        len = 0;
        if (skip) begin
            skip = 0;
            if (!ml && b == rsl_pkg::CH_NL) begin
                len = p;
                return rsl_pkg::ST_UNTERM;
            end
            return rsl_pkg::ST_NONE;
        end
        if (esc_coll) begin
            if (b == rsl_pkg::CH_HASH) begin
                esc_cnt++;
                if (esc_cnt >= hlev) begin
                    esc_coll = 0;
                    skip = 1;
                end
                return rsl_pkg::ST_NONE;
            end
            esc_coll = 0;
        end
        if (b == rsl_pkg::CH_BSLASH) begin
            qrun = 0;
            close_cnt = 0;
            if (hlev == 0) begin
                skip = 1;
            end else begin
                esc_coll = 1;
                esc_cnt = 0;
            end
            return rsl_pkg::ST_NONE;
        end
        if (b == rsl_pkg::CH_NL) begin
            qrun = 0;
            close_cnt = 0;
            if (!ml) begin
                len = p;
                return rsl_pkg::ST_UNTERM;
            end
            return rsl_pkg::ST_NONE;
        end
        if (b == rsl_pkg::CH_QUOTE) begin
            // a quote after closing hashes starts a fresh candidate
            if (close_cnt > 0) begin
                qrun = 1;
                close_cnt = 0;
            end else if (qrun < need) begin
                qrun++;
            end
            if (qrun == need && hlev == 0) begin
                len = p + 1;
                return rsl_pkg::ST_TERM;
            end
            return rsl_pkg::ST_NONE;
        end
        if (b == rsl_pkg::CH_HASH) begin
            if (qrun == need) begin
                close_cnt++;
                if (close_cnt >= hlev) begin
                    len = p + 1;
                    return rsl_pkg::ST_TERM;
                end
            end else begin
                qrun = 0;
                close_cnt = 0;
            end
            return rsl_pkg::ST_NONE;
        end
        qrun = 0;
        close_cnt = 0;
        return rsl_pkg::ST_NONE;
    endfunction

    function void take_byte(rsl_pkg::t_in_item it);
        logic [7:0]       b;
        bit               last;
        int unsigned      p;
        int unsigned      len;
        int unsigned      k;
        bit               got;
        bit               go_multi;
        bit               go_single;
        rsl_pkg::t_status st;
        rsl_pkg::t_result r;
        b = it.source_byte;
        last = it.last_byte;
        p = pos;
        got = 0;
        len = 0;
        go_multi = 0;
        go_single = 0;
        r = '0;
        if (phase != rsl_pkg::PH_DONE && p >= rsl_pkg::MAX_LENGTH) begin
            r = make_result(rsl_pkg::ST_OVER, 0, 0, 0, 0);
            got = 1;
        end else if (phase == rsl_pkg::PH_COUNT) begin
            if (b == rsl_pkg::CH_HASH) begin
                if (hlev >= rsl_pkg::MAX_HASH) begin
                    r = make_result(rsl_pkg::ST_OVER, 0, 0, 0, 0);
                    got = 1;
                end else begin
                    hlev++;
                    if (last) begin
                        r = make_result(rsl_pkg::ST_NONE, 0, 0, 0, 0);
                        got = 1;
                    end
                end
            end else if (b == rsl_pkg::CH_QUOTE) begin
                phase = rsl_pkg::PH_PENDING;
                content_at = p + 1;
                multi = 0;
                clear_scan();
                held_valid = 0;
                if (last) begin
                    r = make_result(rsl_pkg::ST_UNTERM, p + 1, content_at, hlev, 0);
                    got = 1;
                end
            end else begin
                r = make_result(rsl_pkg::ST_NONE, 0, 0, 0, 0);
                got = 1;
            end
        end else if (phase == rsl_pkg::PH_PENDING) begin
            // single-line scan runs on while the multi-line question is open
            k = p - hlev;
            if (!held_valid) begin
                st = scan_body(b, p, 0, len);
                if (st != rsl_pkg::ST_NONE) begin
                    held_valid = 1;
                    held_st = st;
                    held_len = len;
                end
            end
            if (k <= 2) go_single = (b != rsl_pkg::CH_QUOTE);
            else if (b == rsl_pkg::CH_NL) go_multi = 1;
            else if (b == rsl_pkg::CH_HASH || b == rsl_pkg::CH_QUOTE) go_single = 1;
            if (!go_multi && !go_single && last) go_single = 1;
            if (go_multi) begin
                phase = rsl_pkg::PH_SCAN;
                multi = 1;
                content_at = p + 1;
                clear_scan();
                held_valid = 0;
                if (last) begin
                    r = make_result(rsl_pkg::ST_UNTERM, p + 1, content_at, hlev, 1);
                    got = 1;
                end
            end else if (go_single) begin
                phase = rsl_pkg::PH_SCAN;
                if (held_valid) begin
                    r = make_result(held_st, held_len, content_at, hlev, 0);
                    got = 1;
                end else if (last) begin
                    r = make_result(rsl_pkg::ST_UNTERM, p + 1, content_at, hlev, 0);
                    got = 1;
                end
            end
        end else if (phase == rsl_pkg::PH_SCAN) begin
            st = scan_body(b, p, multi, len);
            if (st != rsl_pkg::ST_NONE) begin
                r = make_result(st, len, content_at, hlev, multi);
                got = 1;
            end else if (last) begin
                r = make_result(rsl_pkg::ST_UNTERM, p + 1, content_at, hlev, multi);
                got = 1;
            end
        end
        if (got) awaited_results.push_back(r);
        if (last) begin
            restart();
        end else begin
            if (got) phase = rsl_pkg::PH_DONE;
            if (pos != 32'hFFFF_FFFF) pos++;
        end
    endfunction

    function void check_result(rsl_pkg::t_result got);
        rsl_pkg::t_result want;
        if (awaited_results.size() == 0) begin
            errors++;
            if (reported < 10) begin
                reported++;
                $display("unexpected result: st=%0d len=%0d cs=%0d h=%0d ml=%0d",
                         got.scan_status, got.literal_length, got.content_start,
                         got.hash_count, got.is_multi_line);
            end
            return;
        end
        want = awaited_results.pop_front();
        status_seen[want.scan_status]++;
        if (want.is_multi_line) multi_seen++;
        if (got.scan_status !== want.scan_status ||
            got.literal_length !== want.literal_length ||
            got.content_start !== want.content_start ||
            got.hash_count !== want.hash_count ||
            got.is_multi_line !== want.is_multi_line) begin
            errors++;
            if (reported < 10) begin
                reported++;
                $display("mismatch: expected st=%0d len=%0d cs=%0d h=%0d ml=%0d",
                         want.scan_status, want.literal_length, want.content_start,
                         want.hash_count, want.is_multi_line);
                $display("          actual   st=%0d len=%0d cs=%0d h=%0d ml=%0d",
                         got.scan_status, got.literal_length, got.content_start,
                         got.hash_count, got.is_multi_line);
            end
        end
    endfunction

    function int unsigned waiting();
        return awaited_results.size();
    endfunction
endclass

module raw_string_literal_delimiter_scanner_test;

    localparam int unsigned RANDOM_BYTES = 2000;
    localparam int unsigned IDLE_LIMIT   = 2000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    rsl_pkg::t_in_item i_in_item;
    logic              o_out_valid;
    logic              i_out_stall;
    rsl_pkg::t_result  o_result;

    literal_checker book = new();

    logic [7:0]  text_q[$];
    int unsigned bytes_sent;
    int unsigned texts_sent;
    bit          tx_quiet;
    bit          rx_quiet;

    raw_string_literal_delimiter_scanner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(logic [7:0] b, bit last);
        rsl_pkg::t_in_item it;
        int unsigned       g;
        it.source_byte = b;
        it.last_byte = last;
        g = tx_quiet ? 0 : gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        book.take_byte(it);
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
        text_q.delete();
        texts_sent++;
    endtask

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    task automatic push_run(logic [7:0] b, int unsigned n);
        repeat (n) text_q.push_back(b);
    endtask

    task automatic add_piece(int unsigned h, bit ml);
        int unsigned need;
        int unsigned n;
        need = ml ? 3 : 1;
        case ($urandom_range(0, 9))
            0, 1: text_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
            2: text_q.push_back(8'($urandom_range(0, 255)));
            3: text_q.push_back(rsl_pkg::CH_QUOTE);
            4: text_q.push_back(rsl_pkg::CH_HASH);
            5: begin
                // escape, sometimes with too few hashes
                text_q.push_back(rsl_pkg::CH_BSLASH);
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, h) : h;
                push_run(rsl_pkg::CH_HASH, n);
                case ($urandom_range(0, 3))
                    0: text_q.push_back(rsl_pkg::CH_QUOTE);
                    1: text_q.push_back(rsl_pkg::CH_HASH);
                    2: text_q.push_back(rsl_pkg::CH_NL);
                    default: text_q.push_back(8'h71);
                endcase
            end
            6: text_q.push_back((ml || $urandom_range(0, 3) == 0) ? rsl_pkg::CH_NL : 8'h62);
            7: begin
                push_run(rsl_pkg::CH_QUOTE, $urandom_range(1, need));
                push_run(rsl_pkg::CH_HASH, $urandom_range(0, h));
            end
            default: begin
                if ($urandom_range(0, 2) == 0) begin
                    push_run(rsl_pkg::CH_QUOTE, need);
                    push_run(rsl_pkg::CH_HASH, h);
                end else begin
                    text_q.push_back(8'h7A);
                end
            end
        endcase
    endtask

    task automatic build_random_text();
        int unsigned r;
        int unsigned h;
        int unsigned form;
        bit          ml;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            text_q.push_back(($urandom_range(0, 1) == 0) ? rsl_pkg::CH_HASH
                                                         : 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 5)) text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 60) h = 0;
        else if (r < 80) h = $urandom_range(1, 3);
        else if (r < 92) h = $urandom_range(4, 9);
        else if (r < 97) h = $urandom_range(28, 31);
        else h = $urandom_range(32, 34);
        push_run(rsl_pkg::CH_HASH, h);
        form = $urandom_range(0, 5);
        ml = (form == 3);
        case (form)
            3: begin
                push_run(rsl_pkg::CH_QUOTE, 3);
                text_q.push_back(rsl_pkg::CH_NL);
            end
            4: push_run(rsl_pkg::CH_QUOTE, 3);
            5: push_run(rsl_pkg::CH_QUOTE, 2);
            default: text_q.push_back(rsl_pkg::CH_QUOTE);
        endcase
        repeat ($urandom_range(0, 10)) add_piece(h, ml);
        repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // sink side with random stall
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        rx_quiet = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) book.check_result(o_result);
            if ($urandom_range(0, 299) == 0) rx_quiet = !rx_quiet;
            if (stall_left == 0 && !rx_quiet && $urandom_range(0, 2) == 0)
                stall_left = gap_len();
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int unsigned random_start;
        bytes_sent = 0;
        texts_sent = 0;
        tx_quiet = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        text_q.push_back(8'h00);
        send_text();
        text_q.push_back(8'hFF);
        send_text();
        push_str("##");
        send_text();
        push_str("\"ab\"");
        send_text();
        push_str("\"a\nb");
        send_text();
        push_str("#\"a\"#");
        send_text();
        push_str("\"\"\"\nx\"\"\"");
        send_text();
        push_str("\"\"x");
        send_text();
        push_str("\"\\\n");
        send_text();
        push_str("\"\\\"");
        send_text();
        push_str("\"\"\"\n");
        send_text();

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            if ($urandom_range(0, 4) == 0) tx_quiet = !tx_quiet;
            build_random_text();
            send_text();
        end

        i_in_valid <= 1'b0;
        while (book.waiting() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Scanned %0d bytes in %0d texts, %0d of them multi-line literals.",
                 bytes_sent, texts_sent, book.multi_seen);
        $display("Results: %0d not a literal, %0d terminated, %0d unterminated, %0d overflow.",
                 book.status_seen[rsl_pkg::ST_NONE], book.status_seen[rsl_pkg::ST_TERM],
                 book.status_seen[rsl_pkg::ST_UNTERM], book.status_seen[rsl_pkg::ST_OVER]);
        if (book.errors == 0 && book.waiting() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
